@@ rtl/deq_pkg.sv @@
// deq_pkg: shared constants, types and operation codes of the double-ended queue
// no dependencies
package deq_pkg;

    localparam int DEPTH     = 16;
    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 3;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int OUT_CNT_W = 5;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [FUNC_W-1:0]        func_t;

    localparam func_t FUNC_PUSH_FRONT = 3'd0;
    localparam func_t FUNC_PUSH_REAR  = 3'd1;
    localparam func_t FUNC_POP_FRONT  = 3'd2;
    localparam func_t FUNC_POP_REAR   = 3'd3;
    localparam func_t FUNC_CLEAR      = 3'd4;
    localparam func_t FUNC_QUERY      = 3'd5;

    localparam data_t EMPTY_WORD = '1;

    // per-chain operation, the near end is cell 0
    typedef struct packed {
        logic push_near;
        logic pop_near;
        logic push_far;
        logic pop_far;
        logic clear;
    } cell_ctrl_t;

endpackage

@@ rtl/deq_cell.sv @@
// deq_cell: one storage position of a deque chain, a word and a valid bit
// depends on deq_pkg
module deq_cell
    import deq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  data_t      far_data,
    input  data_t      left_data,
    input  logic       left_valid,
    input  data_t      right_data,
    input  logic       right_valid,
    output data_t      data_q,
    output logic       valid_q,
    output data_t      data_d
);

    data_t data_reg, data_next;
    logic  valid_reg, valid_next;

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (ctrl.push_near) begin
            data_next  = left_data;
            valid_next = left_valid;
        end else if (ctrl.pop_near) begin
            data_next  = right_data;
            valid_next = right_valid;
        end else if (ctrl.push_far && !valid_reg && left_valid) begin
            // first free position past the occupied run
            data_next  = far_data;
            valid_next = 1'b1;
        end else if (ctrl.pop_far && valid_reg && !right_valid) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_q  = data_reg;
    assign valid_q = valid_reg;
    assign data_d  = data_next;

endmodule

@@ rtl/deq_chain.sv @@
// deq_chain: a row of deq_cell positions, cell 0 at the near end
// depends on deq_pkg and deq_cell
module deq_chain
    import deq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  data_t      value,
    output data_t      near_data_next
);

    data_t data_q  [DEPTH];
    data_t data_d  [DEPTH];
    logic  valid_q [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        data_t l_data, r_data;
        logic  l_valid, r_valid;

        if (i == 0) begin : g_first
            // the pushed item enters from outside the near end
            assign l_data  = value;
            assign l_valid = 1'b1;
        end else begin : g_mid_l
            assign l_data  = data_q[i-1];
            assign l_valid = valid_q[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign r_data  = '0;
            assign r_valid = 1'b0;
        end else begin : g_mid_r
            assign r_data  = data_q[i+1];
            assign r_valid = valid_q[i+1];
        end

        deq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .far_data    (value),
            .left_data   (l_data),
            .left_valid  (l_valid),
            .right_data  (r_data),
            .right_valid (r_valid),
            .data_q      (data_q[i]),
            .valid_q     (valid_q[i]),
            .data_d      (data_d[i])
        );
    end

    assign near_data_next = data_d[0];

endmodule

@@ rtl/double_ended_queue_top.sv @@
// double_ended_queue_top: bounded deque held in two mirrored cell chains
// depends on deq_pkg and deq_chain
// result: an accepted item's result is registered into the output register at its accept clock edge
// throughput: one item per cycle while s_ready is high; every cell updates from its neighbours in the accept cycle
// the output register frees as its result is taken, so input and output overlap
// reset: synchronous active low, clears count, valid bits and output valid; words undefined
module double_ended_queue_top
    import deq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  func_t                 s_func,
    input  data_t                 s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output data_t                 m_front_value,
    output data_t                 m_rear_value,
    output logic [OUT_CNT_W-1:0]  m_count,
    output logic                  m_is_empty,
    output logic                  m_overflow,
    output logic                  m_underflow
);

    cnt_t       count_reg, count_next;
    logic       m_valid_reg, m_valid_next;
    data_t      front_reg, rear_reg;
    logic [OUT_CNT_W-1:0] cnt_out_reg;
    logic       empty_reg, ovf_reg, unf_reg;
    logic       take, full, empty, ovf, unf;
    logic       do_pf, do_pr, do_popf, do_popr, do_clr;
    cell_ctrl_t ctrl_a, ctrl_b;
    data_t      a_near_next, b_near_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    always_comb begin
        do_pf   = 1'b0;
        do_pr   = 1'b0;
        do_popf = 1'b0;
        do_popr = 1'b0;
        do_clr  = 1'b0;
        ovf     = 1'b0;
        unf     = 1'b0;
        case (s_func)
            FUNC_PUSH_FRONT: begin
                ovf   = full;
                do_pf = take && !full;
            end
            FUNC_PUSH_REAR: begin
                ovf   = full;
                do_pr = take && !full;
            end
            FUNC_POP_FRONT: begin
                unf     = empty;
                do_popf = take && !empty;
            end
            FUNC_POP_REAR: begin
                unf     = empty;
                do_popr = take && !empty;
            end
            FUNC_CLEAR: begin
                do_clr = take;
            end
            FUNC_QUERY: begin
            end
            default: begin
            end
        endcase
    end

    // chain a keeps the front at cell 0, chain b keeps the rear at cell 0
    always_comb begin
        ctrl_a.push_near = do_pf;
        ctrl_a.pop_near  = do_popf;
        ctrl_a.push_far  = do_pr;
        ctrl_a.pop_far   = do_popr;
        ctrl_a.clear     = do_clr;
        ctrl_b.push_near = do_pr;
        ctrl_b.pop_near  = do_popr;
        ctrl_b.push_far  = do_pf;
        ctrl_b.pop_far   = do_popf;
        ctrl_b.clear     = do_clr;
    end

    always_comb begin
        count_next = count_reg;
        if (do_clr) begin
            count_next = '0;
        end else if (do_pf || do_pr) begin
            count_next = count_reg + 1'b1;
        end else if (do_popf || do_popr) begin
            count_next = count_reg - 1'b1;
        end
    end

    deq_chain u_front_chain (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl_a),
        .value          (s_value),
        .near_data_next (a_near_next)
    );

    deq_chain u_rear_chain (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl_b),
        .value          (s_value),
        .near_data_next (b_near_next)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            front_reg   <= (count_next == '0) ? EMPTY_WORD : a_near_next;
            rear_reg    <= (count_next == '0) ? EMPTY_WORD : b_near_next;
            cnt_out_reg <= OUT_CNT_W'(count_next);
            empty_reg   <= (count_next == '0);
            ovf_reg     <= ovf;
            unf_reg     <= unf;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_front_value = front_reg;
    assign m_rear_value  = rear_reg;
    assign m_count       = cnt_out_reg;
    assign m_is_empty    = empty_reg;
    assign m_overflow    = ovf_reg;
    assign m_underflow   = unf_reg;

endmodule

@@ rtl/deq_checker.sv @@
// deq_checker: port-level assertions for double_ended_queue_top, bound to it below
// depends on deq_pkg
module deq_checker
    import deq_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input data_t                 m_front_value,
    input data_t                 m_rear_value,
    input logic [OUT_CNT_W-1:0]  m_count,
    input logic                  m_is_empty,
    input logic                  m_overflow,
    input logic                  m_underflow
);

    // a stalled result item holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_front_value)
            && $stable(m_rear_value) && $stable(m_count))
        else $error("result item changed while stalled");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_empty == (m_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_words: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_empty |-> (m_front_value == EMPTY_WORD)
            && (m_rear_value == EMPTY_WORD) && !m_overflow)
        else $error("empty queue shows stored words or overflow");

    a_single_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_count == OUT_CNT_W'(1)) |-> (m_front_value == m_rear_value)
            && !m_underflow && !m_overflow)
        else $error("single entry differs at the two ends");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_front_value (m_front_value),
    .m_rear_value  (m_rear_value),
    .m_count       (m_count),
    .m_is_empty    (m_is_empty),
    .m_overflow    (m_overflow),
    .m_underflow   (m_underflow)
);
